FILE: rtl/core/voxel_splat_projector_macros.svh
// ----------------------------------------------------------------------------
// Voxel splat projector: assertion macros
// Concurrent checks on the rising edge of clock, switched off during reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SPLAT_PROJECTOR_MACROS_SVH
`define VOXEL_SPLAT_PROJECTOR_MACROS_SVH

// Same-cycle implication
`define VSP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define VSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/vsp_pkg.sv
// ----------------------------------------------------------------------------
// Voxel splat projector package
// Shared widths, register indexes, item and queue entry types.
// ----------------------------------------------------------------------------
package vsp_pkg;

   // Fixed field and register widths
   localparam int CFG_W     = 18;
   localparam int SIZE_W    = 9;
   localparam int CSR_IDX_W = 3;
   localparam int MAX_DIM   = 256;
   localparam int STORE_AW  = 16;
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int ACC_W     = 48;
   localparam int ADD_W     = 33;
   localparam int VAL_W     = 32;
   localparam int COEF_FRAC = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COS_PHI   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_PHI   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_THETA = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_THETA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAT_MODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z    = 3'd7;

   // Item kinds
   localparam logic KIND_SPLAT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = 2;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              voxel_x;
      logic [7:0]              voxel_y;
      logic [7:0]              voxel_z;
      logic signed [VAL_W-1:0] voxel_value;
      logic [15:0]             read_index;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] pixel_value;
      logic [15:0]             pixel_index;
   } rsp_type;

   // One store access: add into an entry, or read and clear it
   typedef struct packed {
      logic                    is_read;
      logic [STORE_AW-1:0]     addr;
      logic signed [ADD_W-1:0] add;
   } op_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_MATRIX,
      FS_PROJECT,
      FS_PUSH,
      FS_READ
   } front_state_type;

endpackage

FILE: rtl/core/vsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, read-first.
// ----------------------------------------------------------------------------
module vsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

FILE: rtl/core/vsp_op_queue.sv
// ----------------------------------------------------------------------------
// Store access queue
// Short FIFO of store operations between the front and the back.
// ----------------------------------------------------------------------------
`include "voxel_splat_projector_macros.svh"
module vsp_op_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  vsp_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output vsp_pkg::op_type head_op,
   output logic            empty
);
   import vsp_pkg::*;

   op_type             q_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign full    = (count_ff == (Q_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = q_ff[rd_ptr_ff];

   `VSP_ASSERT_IMPL(a_no_overflow, push, !full || pop, "push into full queue")
   `VSP_ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

FILE: rtl/core/vsp_front.sv
// ----------------------------------------------------------------------------
// Projector front end
// Holds configuration, takes items, rotates voxels on a shared multiplier and
// queues bilinear store adds, linear in flat mode, for each one in the image.
// ----------------------------------------------------------------------------
`include "voxel_splat_projector_macros.svh"
module vsp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start_accept,
   input  vsp_pkg::req_type                   req_item,
   input  logic                               csr_we,
   input  logic [vsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vsp_pkg::CFG_W-1:0]          csr_data,
   input  logic                               queue_full,
   output logic                               busy,
   output logic                               push,
   output vsp_pkg::op_type                    push_op
);
   import vsp_pkg::*;

   localparam int FRAC     = COEF_FRAC;
   localparam int POS_FRAC = FRAC + 1;
   localparam int M_W      = 21;
   localparam int POS_W    = 36;
   localparam int MUL_A_W  = 36;
   localparam int MUL_B_W  = 21;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int T_W      = 11;

   // Configuration registers
   logic signed [CFG_W-1:0] cos_phi_ff, sin_phi_ff, cos_theta_ff, sin_theta_ff;
   logic                    flat_ff;
   logic [SIZE_W-1:0]       size_x_ff, size_y_ff, size_z_ff;
   logic                    dirty_ff;

   front_state_type state_ff, state_in;
   logic [3:0]      step_ff;
   logic [1:0]      tap_idx_ff;
   logic [1:0]      tap_last_ff;

   req_type                    item_ff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [SUM_W-1:0]    prod_x;

   logic signed [MUL_A_W-1:0]  a_ff, b_ff, e_ff, f_ff, h_ff;
   logic signed [M_W-1:0]      m0_ff, m3_ff, m4_ff, m6_ff, m7_ff;
   logic signed [M_W-1:0]      m0e, m1e, m3e, m4e, m6e, m7e;
   logic signed [POS_W-1:0]    px_ff, py_ff, lim_x, lim_y;
   logic signed [ADD_W-1:0]    wa_ff, wb_ff;
   logic signed [ADD_W-1:0]    tap_add_ff [4];
   logic [STORE_AW-1:0]        base_ff, tap_addr;
   logic [SIZE_W-1:0]          nx, ny, nz;
   logic signed [T_W-1:0]      tx, ty, tz;
   logic [7:0]                 ix, iy;
   logic [POS_FRAC-1:0]        fx, fy;
   logic [POS_FRAC:0]          ufx, ufy;
   logic                       in_image;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(MAX_DIM)) begin
         r = SIZE_W'(MAX_DIM);
      end
      return r;
   endfunction

   // Round half up, dropping 2*FRAC fraction bits
   function automatic logic signed [M_W-1:0] rnd_coef(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v + (SUM_W'(1) <<< (2*FRAC - 1));
      return t[2*FRAC +: M_W];
   endfunction

   // Round half up, dropping FRAC fraction bits
   function automatic logic signed [M_W-1:0] rnd_frac(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v + (SUM_W'(1) <<< (FRAC - 1));
      return t[FRAC +: M_W];
   endfunction

   // Round half up, dropping the weight fraction bits
   function automatic logic signed [ADD_W-1:0] rnd_wt(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v + (SUM_W'(1) <<< (POS_FRAC - 1));
      return t[POS_FRAC +: ADD_W];
   endfunction

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_phi_ff   <= CFG_W'(65536);
         sin_phi_ff   <= '0;
         cos_theta_ff <= CFG_W'(65536);
         sin_theta_ff <= '0;
         flat_ff      <= 1'b0;
         size_x_ff    <= SIZE_W'(MAX_DIM);
         size_y_ff    <= SIZE_W'(MAX_DIM);
         size_z_ff    <= SIZE_W'(MAX_DIM);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COS_PHI:   cos_phi_ff   <= csr_data;
            CSR_SIN_PHI:   sin_phi_ff   <= csr_data;
            CSR_COS_THETA: cos_theta_ff <= csr_data;
            CSR_SIN_THETA: sin_theta_ff <= csr_data;
            CSR_FLAT_MODE: flat_ff      <= csr_data[0];
            CSR_SIZE_X:    size_x_ff    <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Y:    size_y_ff    <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Z:    size_z_ff    <= csr_data[SIZE_W-1:0];
         endcase
      end
   end

   // Derived geometry
   always_comb begin
      nx  = clamp_size(size_x_ff);
      ny  = clamp_size(size_y_ff);
      nz  = clamp_size(size_z_ff);
      tx  = $signed(T_W'({item_ff.voxel_x, 1'b0})) - $signed(T_W'(nx));
      ty  = $signed(T_W'({item_ff.voxel_y, 1'b0})) - $signed(T_W'(ny));
      tz  = $signed(T_W'({item_ff.voxel_z, 1'b0})) - $signed(T_W'(nz));
      m0e = flat_ff ? M_W'(cos_phi_ff) : m0_ff;
      m1e = flat_ff ? M_W'(sin_phi_ff) : m3_ff;
      m3e = flat_ff ? -M_W'(sin_phi_ff) : m3_ff;
      m4e = flat_ff ? M_W'(cos_phi_ff) : m4_ff;
      m6e = flat_ff ? '0 : m6_ff;
      m7e = flat_ff ? '0 : m7_ff;
      lim_x  = $signed(POS_W'(nx - SIZE_W'(1))) <<< POS_FRAC;
      lim_y  = $signed(POS_W'(ny - SIZE_W'(1))) <<< POS_FRAC;
      in_image = (px_ff > 0) && (px_ff < lim_x)
                 && (flat_ff || ((py_ff > 0) && (py_ff < lim_y)));
      ix  = px_ff[POS_FRAC +: 8];
      iy  = py_ff[POS_FRAC +: 8];
      fx  = px_ff[POS_FRAC-1:0];
      fy  = py_ff[POS_FRAC-1:0];
      ufx = {1'b1, {POS_FRAC{1'b0}}} - {1'b0, fx};
      ufy = {1'b1, {POS_FRAC{1'b0}}} - {1'b0, fy};
      prod_x = SUM_W'(prod_ff);
   end

   // Select multiplier operands for this step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == FS_MATRIX) begin
         unique case (step_ff)
            4'd0: begin mul_a = MUL_A_W'(cos_theta_ff); mul_b = MUL_B_W'(cos_phi_ff); end
            4'd1: begin mul_a = MUL_A_W'(sin_phi_ff);   mul_b = MUL_B_W'(sin_phi_ff); end
            4'd2: begin mul_a = MUL_A_W'(cos_phi_ff);   mul_b = MUL_B_W'(sin_phi_ff); end
            4'd3: begin mul_a = MUL_A_W'(cos_theta_ff); mul_b = MUL_B_W'(sin_phi_ff); end
            4'd4: begin mul_a = MUL_A_W'(cos_phi_ff);   mul_b = MUL_B_W'(cos_phi_ff); end
            4'd5: begin mul_a = a_ff;                   mul_b = MUL_B_W'(cos_phi_ff); end
            4'd6: begin mul_a = a_ff;                   mul_b = MUL_B_W'(sin_phi_ff); end
            4'd7: begin mul_a = f_ff;                   mul_b = MUL_B_W'(sin_phi_ff); end
            4'd8: begin mul_a = MUL_A_W'(sin_theta_ff); mul_b = MUL_B_W'(cos_phi_ff); end
            4'd9: begin mul_a = MUL_A_W'(sin_theta_ff); mul_b = MUL_B_W'(sin_phi_ff); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == FS_PROJECT) begin
         unique case (step_ff)
            4'd0:  begin mul_a = MUL_A_W'(tx); mul_b = m0e; end
            4'd1:  begin mul_a = MUL_A_W'(ty); mul_b = m3e; end
            4'd2:  begin mul_a = MUL_A_W'(tz); mul_b = m6e; end
            4'd3:  begin mul_a = MUL_A_W'(tx); mul_b = m1e; end
            4'd4:  begin mul_a = MUL_A_W'(ty); mul_b = m4e; end
            4'd5:  begin mul_a = MUL_A_W'(tz); mul_b = m7e; end
            4'd7:  begin
               mul_a = MUL_A_W'(item_ff.voxel_value);
               mul_b = $signed(MUL_B_W'(ufx));
            end
            4'd8:  begin
               mul_a = MUL_A_W'(item_ff.voxel_value);
               mul_b = $signed(MUL_B_W'(fx));
            end
            4'd9:  begin mul_a = MUL_A_W'(wa_ff); mul_b = $signed(MUL_B_W'(ufy)); end
            4'd10: begin mul_a = MUL_A_W'(wb_ff); mul_b = $signed(MUL_B_W'(ufy)); end
            4'd11: begin mul_a = MUL_A_W'(wa_ff); mul_b = $signed(MUL_B_W'(fy)); end
            4'd12: begin mul_a = MUL_A_W'(wb_ff); mul_b = $signed(MUL_B_W'(fy)); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   // Shared multiplier, registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (start_accept) begin
               if (req_item.kind == KIND_READ) begin
                  state_in = FS_READ;
               end else if (dirty_ff) begin
                  state_in = FS_MATRIX;
               end else begin
                  state_in = FS_PROJECT;
               end
            end
         end
         FS_MATRIX: begin
            if (step_ff == 4'd10) begin
               state_in = FS_PROJECT;
            end
         end
         FS_PROJECT: begin
            priority if (step_ff == 4'd7 && !in_image) begin
               state_in = FS_IDLE;
            end else if (step_ff == 4'd9 && flat_ff) begin
               state_in = FS_PUSH;
            end else if (step_ff == 4'd13) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!queue_full && tap_idx_ff == tap_last_ff) begin
               state_in = FS_IDLE;
            end
         end
         FS_READ: begin
            if (!queue_full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      tap_addr = base_ff + STORE_AW'(tap_idx_ff[0])
                 + (tap_idx_ff[1] ? STORE_AW'(nx) : '0);
      push     = 1'b0;
      push_op  = '0;
      unique case (state_ff)
         FS_PUSH: begin
            push            = !queue_full;
            push_op.is_read = 1'b0;
            push_op.addr    = tap_addr;
            push_op.add     = tap_add_ff[tap_idx_ff];
         end
         FS_READ: begin
            push            = !queue_full;
            push_op.is_read = 1'b1;
            push_op.addr    = item_ff.read_index;
            push_op.add     = '0;
         end
         default: begin
            push    = 1'b0;
            push_op = '0;
         end
      endcase
      busy = (state_ff != FS_IDLE);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FS_IDLE;
         step_ff    <= '0;
         tap_idx_ff <= '0;
         dirty_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_in != state_ff) ? 4'd0 : step_ff + 4'd1;
         if (state_ff != FS_PUSH) begin
            tap_idx_ff <= '0;
         end else if (push) begin
            tap_idx_ff <= tap_idx_ff + 2'd1;
         end
         if (csr_we) begin
            dirty_ff <= 1'b1;
         end else if (state_ff == FS_MATRIX && step_ff == 4'd10) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   // Datapath: hold the item, build coefficients, positions and tap weights
   always_ff @(posedge clock) begin
      if (state_ff == FS_IDLE && start_accept) begin
         item_ff <= req_item;
      end
      if (state_ff == FS_MATRIX) begin
         unique case (step_ff)
            4'd1:  a_ff  <= prod_ff[MUL_A_W-1:0];
            4'd2:  b_ff  <= prod_ff[MUL_A_W-1:0];
            4'd3:  e_ff  <= prod_ff[MUL_A_W-1:0];
            4'd4:  f_ff  <= prod_ff[MUL_A_W-1:0];
            4'd5:  h_ff  <= prod_ff[MUL_A_W-1:0];
            4'd6:  m0_ff <= rnd_coef(prod_x + (SUM_W'(b_ff) <<< FRAC));
            4'd7:  m3_ff <= rnd_coef(prod_x - (SUM_W'(e_ff) <<< FRAC));
            4'd8:  m4_ff <= rnd_coef(prod_x + (SUM_W'(h_ff) <<< FRAC));
            4'd9:  m6_ff <= -rnd_frac(prod_x);
            4'd10: m7_ff <= -rnd_frac(prod_x);
            default: ;
         endcase
      end
      if (state_ff == FS_PROJECT) begin
         unique case (step_ff)
            4'd0: begin
               px_ff <= $signed(POS_W'(nx)) <<< FRAC;
               py_ff <= $signed(POS_W'(ny)) <<< FRAC;
            end
            4'd1, 4'd2, 4'd3: px_ff <= px_ff + POS_W'(prod_ff);
            4'd4, 4'd5, 4'd6: py_ff <= py_ff + POS_W'(prod_ff);
            4'd7: begin
               base_ff <= flat_ff ? STORE_AW'(ix)
                          : STORE_AW'(17'(ix) + 17'(iy) * 17'(nx));
            end
            4'd8: wa_ff <= rnd_wt(prod_x);
            4'd9: begin
               wb_ff <= rnd_wt(prod_x);
               if (flat_ff) begin
                  tap_add_ff[0] <= wa_ff;
                  tap_add_ff[1] <= rnd_wt(prod_x);
                  tap_last_ff   <= 2'd1;
               end
            end
            4'd10: tap_add_ff[0] <= rnd_wt(prod_x);
            4'd11: tap_add_ff[1] <= rnd_wt(prod_x);
            4'd12: tap_add_ff[2] <= rnd_wt(prod_x);
            4'd13: begin
               tap_add_ff[3] <= rnd_wt(prod_x);
               tap_last_ff   <= 2'd3;
            end
            default: ;
         endcase
      end
   end

   `VSP_ASSERT_NEXT(a_accept_busy, start_accept && !busy, state_ff != FS_IDLE,
                    "accepted item left the front idle")
   `VSP_ASSERT_IMPL(a_push_read_kind, push && push_op.is_read, item_ff.kind == KIND_READ,
                    "read pushed for a splat item")

endmodule

FILE: rtl/core/vsp_back.sv
// ----------------------------------------------------------------------------
// Projector back end
// Clears the projection store after reset, then carries out queued
// read-modify-write accesses, one per cycle, with saturating adds.
// ----------------------------------------------------------------------------
`include "voxel_splat_projector_macros.svh"
module vsp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  vsp_pkg::op_type  head_op,
   output logic             pop,
   output logic             clearing,
   output logic             rsp_strobe,
   output vsp_pkg::rsp_type rsp_item
);
   import vsp_pkg::*;

   logic                    clearing_ff;
   logic [STORE_AW-1:0]     clr_addr_ff;
   logic                    s1_valid_ff;
   op_type                  s1_op_ff;
   logic                    wr_valid_ff;
   logic [STORE_AW-1:0]     wr_addr_ff;
   logic signed [ACC_W-1:0] wr_data_ff;
   logic signed [ACC_W-1:0] rdata, old_val, new_val;
   logic signed [ACC_W:0]   sum;
   logic                    ram_we;
   logic [STORE_AW-1:0]     ram_waddr;
   logic signed [ACC_W-1:0] ram_wdata;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_item_ff;

   vsp_ram #(
      .WIDTH (ACC_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (head_op.addr),
      .rdata (rdata)
   );

   assign pop = !empty && !clearing_ff;

   // Forward the last write over the stale read, then add with saturation
   always_comb begin
      old_val = (wr_valid_ff && wr_addr_ff == s1_op_ff.addr) ? wr_data_ff : rdata;
      sum     = (ACC_W+1)'(old_val) + (ACC_W+1)'(s1_op_ff.add);
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         new_val = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         new_val = sum[ACC_W-1:0];
      end
      if (s1_op_ff.is_read) begin
         new_val = '0;
      end
      priority if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else if (s1_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = s1_op_ff.addr;
         ram_wdata = new_val;
      end else begin
         ram_we    = 1'b0;
         ram_waddr = s1_op_ff.addr;
         ram_wdata = new_val;
      end
   end

   // Control: clearing sweep and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff   <= pop;
         wr_valid_ff   <= s1_valid_ff;
         rsp_strobe_ff <= s1_valid_ff && s1_op_ff.is_read;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff <= head_op;
      end
      wr_addr_ff              <= s1_op_ff.addr;
      wr_data_ff              <= new_val;
      rsp_item_ff.pixel_value <= old_val;
      rsp_item_ff.pixel_index <= s1_op_ff.addr;
   end

   assign clearing   = clearing_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `VSP_ASSERT_IMPL(a_rsp_from_pop, rsp_strobe_ff, $past(pop, 2), "result without a popped item")
   `VSP_ASSERT_IMPL(a_no_write_clash, s1_valid_ff, !clearing_ff, "access during clearing sweep")

endmodule

FILE: rtl/core/voxel_splat_projector.sv
// Results: a read item gets its result from the back; splats give none.
// Items: one at a time; a splat holds busy through the shared multiplier sequence,
// run in the front, with a matrix pass first after reset or a configuration write.
// After clearing, the back does one store access per cycle behind a 4-entry queue.
// Reset: synchronous; busy stays high while the store is cleared.
// ----------------------------------------------------------------------------
// Voxel splat projector
// Rotates voxels and splats them bilinearly into a saturating projection store.
// ----------------------------------------------------------------------------
module voxel_splat_projector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  vsp_pkg::req_type              req_item,
   output logic                          rsp_strobe,
   output vsp_pkg::rsp_type              rsp_item,
   input  logic                          csr_we,
   input  logic [vsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vsp_pkg::CFG_W-1:0]     csr_data
);
   import vsp_pkg::*;

   logic   start_accept;
   logic   front_busy;
   logic   clearing;
   logic   push, full, pop, empty;
   op_type push_op, head_op;

   // Accept while neither the front nor the clearing sweep is busy
   assign busy         = front_busy || clearing;
   assign start_accept = start && !busy;

   vsp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start_accept (start_accept),
      .req_item     (req_item),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_full   (full),
      .busy         (front_busy),
      .push         (push),
      .push_op      (push_op)
   );

   vsp_op_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .head_op (head_op),
      .empty   (empty)
   );

   vsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head_op    (head_op),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
